[rtl/lvp_pkg.sv]
// ----------------------------------------------------------------------------
// lvp_pkg: shared constants and types
// Sizes of the position counter, the open-position stack and the result
// fields, plus the control bundle that moves the stack cells.
// ----------------------------------------------------------------------------
package lvp_pkg;

  localparam int MAX_LENGTH  = 65536;
  localparam int STACK_DEPTH = 1024;

  // width of a stored open position (positions stay below MAX_LENGTH)
  localparam int ENTRY_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  // width of the running position, which can reach MAX_LENGTH itself
  localparam int POS_W   = $clog2(MAX_LENGTH + 1);
  // width of the stack count, which can reach STACK_DEPTH itself
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

  localparam int SYMBOL_W  = 8;
  localparam int LONGEST_W = 17;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [SYMBOL_W-1:0] OPEN_BYTE = 8'd40;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

[rtl/longest_valid_parentheses_core.sv]
// ----------------------------------------------------------------------------
// longest_valid_parentheses_core: running longest well-formed bracket run
// One byte per transfer; each byte answers with the best length so far.
// ----------------------------------------------------------------------------
// a result is registered into the output queue and is presented in order
// throughput: one byte per cycle while the output queue has room; the
//   subtract against cell 1 or the base and the compare are combinational
// a two-entry output queue keeps input flowing while a result waits
// reset (rst, synchronous): clears the counters, flags and output queue;
//   stack cells are not cleared, only entries below the count are read
module longest_valid_parentheses_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic [0:0]  s_tuser,   // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] longest, [23:17] zero
  output logic [0:0]  m_tuser    // [0] overflow
);

  localparam int PW = lvp_pkg::POS_W;
  localparam int EW = lvp_pkg::ENTRY_W;
  localparam int CW = lvp_pkg::CNT_W;
  localparam int LW = lvp_pkg::LONGEST_W;

  logic [PW-1:0] position, position_next;
  logic [PW-1:0] base_position, base_position_next;
  logic [CW-1:0] stack_count, stack_count_next;
  logic [LW-1:0] best_length, best_length_next;
  logic          overflow_seen, overflow_seen_next;

  lvp_pkg::stack_op_t     op;
  logic [EW-1:0]          top_value;
  logic [EW-1:0]          second_value;
  logic [EW-1:0]          pos_entry;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  lvp_stack u_stack (
    .clk        (clk),
    .op         (op),
    .push_value (pos_entry),
    .top        (top_value),
    .second     (second_value)
  );

  always_comb begin
    logic [PW-1:0] pos_e;
    logic [PW-1:0] base_e;
    logic [CW-1:0] cnt_e;
    logic [LW-1:0] best_e;
    logic          ovf_e;
    logic [PW-1:0] pos_inc;
    logic [LW-1:0] cand;
    logic          cand_ok;

    pos_e  = s_tuser[0] ? '0 : position;
    base_e = s_tuser[0] ? '0 : base_position;
    cnt_e  = s_tuser[0] ? '0 : stack_count;
    best_e = s_tuser[0] ? '0 : best_length;
    ovf_e  = s_tuser[0] ? 1'b0 : overflow_seen;

    pos_entry = pos_e[EW-1:0];
    pos_inc   = pos_e + PW'(1);
    cand      = '0;
    cand_ok   = 1'b0;

    op                 = '0;
    position_next      = pos_e;
    base_position_next = base_e;
    stack_count_next   = cnt_e;
    overflow_seen_next = ovf_e;

    if (pos_e < PW'(lvp_pkg::MAX_LENGTH)) begin
      position_next = pos_inc;
      if (s_tdata == lvp_pkg::OPEN_BYTE) begin
        if (cnt_e < CW'(lvp_pkg::STACK_DEPTH)) begin
          op.push          = 1'b1;
          stack_count_next = cnt_e + CW'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else if (cnt_e == '0) begin
        base_position_next = pos_inc;
      end else begin
        op.pop           = 1'b1;
        stack_count_next = cnt_e - CW'(1);
        if (cnt_e == CW'(1)) begin
          // stack empties: measure from the base
          cand_ok = pos_inc >= base_e;
          cand    = LW'(pos_inc - base_e);
        end else begin
          // measure from just after the entry that becomes the top
          cand_ok = pos_entry >= second_value;
          cand    = LW'(pos_entry - second_value);
        end
      end
    end

    best_length_next = (cand_ok && cand > best_e) ? cand : best_e;

    if (!in_xfer) begin
      op = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      base_position <= '0;
      stack_count   <= '0;
      best_length   <= '0;
      overflow_seen <= 1'b0;
    end else if (in_xfer) begin
      position      <= position_next;
      base_position <= base_position_next;
      stack_count   <= stack_count_next;
      best_length   <= best_length_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // two-entry result queue
  logic [LW-1:0] q_len [2];
  logic          q_ovf [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    q_count;

  assign s_tready = q_count != 2'd2;
  assign m_tvalid = q_count != 2'd0;
  assign m_tdata  = {(lvp_pkg::OUT_DATA_W - LW)'(0), q_len[rd_ptr]};
  assign m_tuser  = q_ovf[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_len[wr_ptr] <= best_length_next;
      q_ovf[wr_ptr] <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_xfer) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({in_xfer, out_xfer})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

[rtl/lvp_cell.sv]
// ----------------------------------------------------------------------------
// lvp_cell: one slot of the open-position stack
// Takes the value of the neighbor above on a push and of the neighbor below
// on a pop; holds otherwise.
// ----------------------------------------------------------------------------
module lvp_cell (
  input  logic                        clk,
  input  lvp_pkg::stack_op_t          op,
  input  logic [lvp_pkg::ENTRY_W-1:0] from_above,
  input  logic [lvp_pkg::ENTRY_W-1:0] from_below,
  output logic [lvp_pkg::ENTRY_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (op.push) begin
      value <= from_above;
    end else if (op.pop) begin
      value <= from_below;
    end
  end

endmodule

[rtl/lvp_stack.sv]
// ----------------------------------------------------------------------------
// lvp_stack: shifting stack built from a row of cells
// The top of stack always sits in cell 0, the entry under it in cell 1.
// ----------------------------------------------------------------------------
module lvp_stack (
  input  logic                        clk,
  input  lvp_pkg::stack_op_t          op,
  input  logic [lvp_pkg::ENTRY_W-1:0] push_value,
  output logic [lvp_pkg::ENTRY_W-1:0] top,
  output logic [lvp_pkg::ENTRY_W-1:0] second
);

  logic [lvp_pkg::ENTRY_W-1:0] slot [lvp_pkg::STACK_DEPTH];

  for (genvar k = 0; k < lvp_pkg::STACK_DEPTH; k++) begin : g_cell
    logic [lvp_pkg::ENTRY_W-1:0] above;
    logic [lvp_pkg::ENTRY_W-1:0] below;

    if (k == 0) begin : g_head
      assign above = push_value;
    end else begin : g_body
      assign above = slot[k-1];
    end

    if (k == lvp_pkg::STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_inner
      assign below = slot[k+1];
    end

    lvp_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .value      (slot[k])
    );
  end

  assign top = slot[0];

  // with a single slot there is never an entry under the top
  if (lvp_pkg::STACK_DEPTH > 1) begin : g_second
    assign second = slot[1];
  end else begin : g_no_second
    assign second = '0;
  end

endmodule
